/* sv/valve_switch_sequencer_defines.svh */
// Assertion macros for the valve switch sequencer.
`ifndef VALVE_SWITCH_SEQUENCER_DEFINES_SVH
`define VALVE_SWITCH_SEQUENCER_DEFINES_SVH
// Concurrent check with asynchronous reset disable.
`define VSS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Signal must be zero while a condition holds.
`define VSS_ASSERT_ZERO(lbl, clk, rst_n, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ((sig) == '0)) \
		else $error("value not zero");
`endif

/* sv/vss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_pkg
// Types and constants shared by the valve switch sequencer.
// ----------------------------------------------------------------------------
package vss_pkg;
	localparam int NUM_VALVES_DEF      = 10;
	localparam int FULL_DUTY_COUNT_DEF = 4500;
	localparam int CLOSE_DELAY_CAP_DEF = 1000;
	localparam int OPEN_DELAY_CAP_DEF  = 100;

	localparam logic [15:0] IO_BITS = 16'hFFF0;
	localparam logic [15:0] EX_BITS = 16'h007F;
	localparam logic [12:0] CMP_MAX = 13'd8191;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_REQ   = 2'd1;
	localparam logic [1:0] ACT_BREAK = 2'd2;

	localparam logic [2:0] REG_EXT   = 3'd0;
	localparam logic [2:0] REG_DUTY  = 3'd1;
	localparam logic [2:0] REG_CDLY  = 3'd2;
	localparam logic [2:0] REG_STEPS = 3'd3;
	localparam logic [2:0] REG_ODLY  = 3'd4;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_CLOSE = 2'd1;
	localparam logic [1:0] PH_OPEN  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] request_mask;
	} in_word_t;

	typedef struct packed {
		logic [15:0] full_on_mask;
		logic [15:0] hold_pwm_mask;
		logic [15:0] ramp_pwm_mask;
		logic [12:0] hold_compare;
		logic [12:0] ramp_compare;
		logic [15:0] valve_status;
		logic [1:0]  seq_phase;
		logic        done_res;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch input, load working copies on request
		logic start;     // compute target and sets
		logic div_init;  // start both dividers
		logic div_step;  // one quotient bit
		logic close_go;  // enter closing with quotients
		logic open_go;   // begin open phase, or finish if none to open
		logic tick;      // run one tick
		logic emit;      // build output word
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_req;
		logic is_break;
		logic is_tick;
		logic closing_nz;
		logic div_last;
	} dp_stat_t;
endpackage

/* sv/vss_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_stream_if
// Valid/ready channel carrying one word.
// ----------------------------------------------------------------------------
interface vss_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* sv/valve_switch_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_switch_sequencer
// Closes and opens a bank of valves in PWM ramp / full drive sequences.
// ----------------------------------------------------------------------------
// One word in gives one word out. A tick runs the tick step, and the open
// step as well when it ends the closing ramp; an ignored action goes on
// to emit. A request or force break with valves to close runs the 16-step
// restoring dividers that form the ramp decrement and step period; one
// with none to close goes on to the open step without them.
// One word is in work at a time; the next is taken once the result stands
// in the output register.
module valve_switch_sequencer #(
	parameter int NUM_VALVES      = vss_pkg::NUM_VALVES_DEF,
	parameter int FULL_DUTY_COUNT = vss_pkg::FULL_DUTY_COUNT_DEF,
	parameter int CLOSE_DELAY_CAP = vss_pkg::CLOSE_DELAY_CAP_DEF,
	parameter int OPEN_DELAY_CAP  = vss_pkg::OPEN_DELAY_CAP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	vss_stream_if.sink  in_ch,
	vss_stream_if.source out_ch
);
	import vss_pkg::*;

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	in_word_t  in_word;
	out_word_t out_word;
	logic      close_end;

	assign in_word     = in_ch.data;
	assign out_ch.data = out_word;

	vss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.close_end(close_end), .stat(stat), .cmd(cmd)
	);

	vss_datapath #(
		.NUM_VALVES(NUM_VALVES), .FULL_DUTY_COUNT(FULL_DUTY_COUNT),
		.CLOSE_DELAY_CAP(CLOSE_DELAY_CAP), .OPEN_DELAY_CAP(OPEN_DELAY_CAP)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_word(in_word), .cmd(cmd), .stat(stat), .close_end(close_end),
		.out_word(out_word)
	);
endmodule

/* sv/vss_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_datapath
// Sequencer state, serial dividers and the tick/ramp logic.
// ----------------------------------------------------------------------------
module vss_datapath #(
	parameter int NUM_VALVES      = vss_pkg::NUM_VALVES_DEF,
	parameter int FULL_DUTY_COUNT = vss_pkg::FULL_DUTY_COUNT_DEF,
	parameter int CLOSE_DELAY_CAP = vss_pkg::CLOSE_DELAY_CAP_DEF,
	parameter int OPEN_DELAY_CAP  = vss_pkg::OPEN_DELAY_CAP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  vss_pkg::in_word_t  in_word,
	input  vss_pkg::dp_cmd_t   cmd,
	output vss_pkg::dp_stat_t  stat,
	output logic               close_end,
	output vss_pkg::out_word_t out_word
);
	import vss_pkg::*;

	localparam int          NV    = (NUM_VALVES > 16) ? 16 : NUM_VALVES;
	localparam logic [15:0] VBITS = 16'((32'hFFFF << (16 - NV)) & 32'hFFFF);
	localparam int          DSTEP = FULL_DUTY_COUNT / 100;
	localparam logic [15:0] CCAP  = 16'(CLOSE_DELAY_CAP);
	localparam logic [15:0] OCAP  = 16'(OPEN_DELAY_CAP);

	logic [15:0] ext_q, cdly_q, odly_q;
	logic [6:0]  duty_q, w_duty_q;
	logic [7:0]  csteps_q;
	logic [15:0] w_cdly_q, w_odly_q;
	logic [1:0]  act_q;
	logic [15:0] req_q;
	logic [1:0]  phase_q;
	logic [15:0] target_q, close_q, open_q, status_q;
	logic [15:0] full_q, pwm_q, ramp_q;
	logic [12:0] rval_q, rdec_q;
	logic [15:0] period_q, msc_q;
	logic [7:0]  steps_q;
	logic        done_q;
	logic [15:0] dnum_a_q, dnum_b_q, quo_a_q, quo_b_q;
	logic [15:0] rem_a_q, rem_b_q;
	logic [3:0]  dcnt_q;

	logic [6:0]  duty_sat;
	logic [31:0] hold_wide;
	logic [12:0] hold_cmp;
	logic [15:0] tgt, cl_delay;
	logic [7:0]  div_d;
	logic [16:0] ra_sh, rb_sh;
	logic [15:0] msc_inc, per_eff;
	logic        elapsed;
	logic [15:0] cvb, ovb;

	always_comb begin
		duty_sat  = (w_duty_q > 7'd100) ? 7'd100 : w_duty_q;
		hold_wide = 32'(DSTEP) * 32'(duty_sat);
		hold_cmp  = (hold_wide > 32'(CMP_MAX)) ? CMP_MAX : hold_wide[12:0];
		tgt       = ((act_q == ACT_REQ ? req_q : 16'd0) & IO_BITS) | (ext_q & EX_BITS);
		cl_delay  = (w_cdly_q > CCAP) ? CCAP : w_cdly_q;
		div_d     = (steps_q == 8'd0) ? 8'd1 : steps_q;
		ra_sh     = {rem_a_q, dnum_a_q[15]};
		rb_sh     = {rem_b_q, dnum_b_q[15]};
		msc_inc   = msc_q + 16'd1;
		per_eff   = (period_q == 16'd0) ? 16'd1 : period_q;
		elapsed   = msc_inc >= per_eff;
		cvb       = close_q & VBITS;
		ovb       = open_q & VBITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= '0; duty_q <= 7'd100; cdly_q <= '0; csteps_q <= '0; odly_q <= '0;
			w_duty_q <= 7'd100; w_cdly_q <= '0; w_odly_q <= '0;
			act_q <= '0; req_q <= '0;
			phase_q <= PH_IDLE; target_q <= '0; close_q <= '0; open_q <= '0;
			status_q <= '0; full_q <= '0; pwm_q <= '0; ramp_q <= '0;
			rval_q <= '0; rdec_q <= '0; period_q <= '0; msc_q <= '0;
			steps_q <= '0; done_q <= 1'b0;
			dnum_a_q <= '0; dnum_b_q <= '0; quo_a_q <= '0; quo_b_q <= '0;
			rem_a_q <= '0; rem_b_q <= '0; dcnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_EXT:   ext_q    <= cfg_data;
					REG_DUTY:  duty_q   <= cfg_data[6:0];
					REG_CDLY:  cdly_q   <= cfg_data;
					REG_STEPS: csteps_q <= cfg_data[7:0];
					REG_ODLY:  odly_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				act_q  <= in_word.action;
				req_q  <= in_word.request_mask;
				done_q <= 1'b0;
				if (in_word.action == ACT_REQ) begin
					w_duty_q <= duty_q;
					w_cdly_q <= cdly_q;
					w_odly_q <= odly_q;
					steps_q  <= csteps_q;
				end
			end
			if (cmd.start) begin
				target_q <= tgt;
				close_q  <= status_q & ~tgt;
				open_q   <= tgt & ~status_q;
				rval_q   <= hold_cmp;
			end
			if (cmd.div_init) begin
				steps_q  <= div_d;
				dnum_a_q <= {3'd0, rval_q};
				dnum_b_q <= cl_delay;
				rem_a_q  <= '0;
				rem_b_q  <= '0;
				dcnt_q   <= '0;
			end
			if (cmd.div_step) begin
				if (ra_sh >= {9'd0, steps_q}) begin
					rem_a_q <= 16'(ra_sh - {9'd0, steps_q});
					quo_a_q <= {quo_a_q[14:0], 1'b1};
				end else begin
					rem_a_q <= ra_sh[15:0];
					quo_a_q <= {quo_a_q[14:0], 1'b0};
				end
				if (rb_sh >= {9'd0, steps_q}) begin
					rem_b_q <= 16'(rb_sh - {9'd0, steps_q});
					quo_b_q <= {quo_b_q[14:0], 1'b1};
				end else begin
					rem_b_q <= rb_sh[15:0];
					quo_b_q <= {quo_b_q[14:0], 1'b0};
				end
				dnum_a_q <= {dnum_a_q[14:0], 1'b0};
				dnum_b_q <= {dnum_b_q[14:0], 1'b0};
				dcnt_q   <= dcnt_q + 4'd1;
			end
			if (cmd.close_go) begin
				rdec_q   <= quo_a_q[12:0];
				period_q <= quo_b_q;
				msc_q    <= '0;
				phase_q  <= PH_CLOSE;
			end
			if (cmd.open_go) begin
				if (open_q != 16'd0) begin
					full_q   <= full_q | ovb;
					pwm_q    <= pwm_q & ~ovb;
					ramp_q   <= ramp_q & ~ovb;
					period_q <= (w_odly_q > OCAP) ? OCAP : w_odly_q;
					msc_q    <= '0;
					phase_q  <= PH_OPEN;
				end else begin
					status_q <= target_q;
					phase_q  <= PH_IDLE;
					done_q   <= 1'b1;
				end
			end
			if (cmd.tick && phase_q != PH_IDLE) begin
				msc_q <= elapsed ? 16'd0 : msc_inc;
				if (elapsed) begin
					if (phase_q == PH_CLOSE) begin
						steps_q <= steps_q - 8'd1;
						full_q  <= full_q & ~cvb;
						pwm_q   <= pwm_q & ~cvb;
						if (steps_q != 8'd1) begin
							rval_q <= (rval_q > rdec_q) ? rval_q - rdec_q : 13'd0;
							ramp_q <= ramp_q | cvb;
						end else begin
							rval_q <= '0;
							ramp_q <= ramp_q & ~cvb;
						end
					end else begin
						pwm_q    <= pwm_q | ovb;
						full_q   <= full_q & ~ovb;
						ramp_q   <= ramp_q & ~ovb;
						status_q <= target_q;
						phase_q  <= PH_IDLE;
						done_q   <= 1'b1;
					end
				end
			end
		end
	end

	// last close step hands over to opening; controller issues open_go next
	always_comb begin
		stat.is_req     = act_q == ACT_REQ;
		stat.is_break   = act_q == ACT_BREAK;
		stat.is_tick    = act_q == ACT_TICK;
		stat.closing_nz = close_q != 16'd0;
		stat.div_last   = dcnt_q == 4'd15;
		close_end       = (phase_q == PH_CLOSE) && elapsed && (steps_q == 8'd1);
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word.full_on_mask  <= full_q;
			out_word.hold_pwm_mask <= pwm_q;
			out_word.ramp_pwm_mask <= ramp_q;
			out_word.hold_compare  <= hold_cmp;
			out_word.ramp_compare  <= (phase_q == PH_CLOSE) ? rval_q : 13'd0;
			out_word.valve_status  <= status_q;
			out_word.seq_phase     <= done_q ? PH_DONE : phase_q;
			out_word.done_res      <= done_q;
		end
	end
endmodule

/* sv/vss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_ctrl
// Sequencing of one word: decode, start, divide, tick, emit, handshake.
// ----------------------------------------------------------------------------
`include "valve_switch_sequencer_defines.svh"
module vss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              close_end,
	input  vss_pkg::dp_stat_t stat,
	output vss_pkg::dp_cmd_t  cmd
);
	import vss_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DEC   = 8'b0000_0010,
		S_START = 8'b0000_0100,
		S_DINIT = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_OPEN  = 8'b0010_0000,
		S_TICK  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   ovalid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ovalid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.load = 1'b1;
				state_d  = S_DEC;
			end
			S_DEC: begin
				if (stat.is_req || stat.is_break) state_d = S_START;
				else if (stat.is_tick) state_d = S_TICK;
				else state_d = S_EMIT;
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_DINIT;
			end
			S_DINIT: begin
				if (stat.closing_nz) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else state_d = S_OPEN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_OPEN;
			end
			S_OPEN: begin
				if (stat.closing_nz && !stat.is_tick) cmd.close_go = 1'b1;
				else cmd.open_go = 1'b1;
				state_d = S_EMIT;
			end
			S_TICK: begin
				cmd.tick = 1'b1;
				state_d  = close_end ? S_OPEN : S_EMIT;
			end
			S_EMIT: if (!ovalid_q || out_ready) begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	`VSS_ASSERT(a_onehot, clk, arst_n, $onehot(state_q))
	`VSS_ASSERT(a_emit_idle, clk, arst_n, cmd.emit |=> state_q == S_IDLE)
	`VSS_ASSERT(a_emit_valid, clk, arst_n, cmd.emit |=> out_valid)
	`VSS_ASSERT_ZERO(a_no_load_busy, clk, arst_n, state_q != S_IDLE, cmd.load)
endmodule

/* sim/valve_switch_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_switch_sequencer_tb
// Self-checking bench: drives requests, breaks, ms ticks and ignored
// actions through the valid/ready channels, predicts every output word with
// an internal model of the valve sequencer and compares whole words, across register sets.
// ----------------------------------------------------------------------------
module valve_switch_sequencer_tb;
	import vss_pkg::*;

	localparam int NV = NUM_VALVES_DEF;

	class valve_scoreboard;
		out_word_t pending[$];
		int errors;
		int checked;
		int done_seen;
		logic [15:0] r_ext;
		logic [6:0]  r_duty;
		logic [15:0] r_cdly;
		logic [7:0]  r_steps;
		logic [15:0] r_odly;
		logic [6:0]  w_duty;
		logic [15:0] w_cdly, w_odly;
		logic [1:0]  ph;
		logic [15:0] target, closing, opening, status;
		logic [15:0] full_d, pwm_d, ramp_d;
		logic [12:0] ramp_val, ramp_dec;
		logic [15:0] period, ms_cnt;
		logic [7:0]  steps_left;
		bit          fin;

		function new();
			errors = 0;
			checked = 0;
			done_seen = 0;
			r_ext = '0; r_duty = 7'd100; r_cdly = '0; r_steps = '0; r_odly = '0;
			w_duty = 7'd100; w_cdly = '0; w_odly = '0;
			ph = PH_IDLE;
			target = '0; closing = '0; opening = '0; status = '0;
			full_d = '0; pwm_d = '0; ramp_d = '0;
			ramp_val = '0; ramp_dec = '0; period = '0; ms_cnt = '0; steps_left = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] v);
			case (idx)
				REG_EXT:   r_ext = v;
				REG_DUTY:  r_duty = v[6:0];
				REG_CDLY:  r_cdly = v;
				REG_STEPS: r_steps = v[7:0];
				REG_ODLY:  r_odly = v;
				default: ;
			endcase
		endfunction

		function logic [15:0] valve_bits();
			logic [15:0] m;
			m = '0;
			for (int i = 0; i < NV && i < 16; i++) m[15 - i] = 1'b1;
			return m;
		endfunction

		function logic [12:0] hold_value();
			int d, v;
			d = (w_duty > 100) ? 100 : int'(w_duty);
			v = (FULL_DUTY_COUNT_DEF / 100) * d;
			return (v > 8191) ? 13'd8191 : v[12:0];
		endfunction

		function void finish();
			status = target;
			ph = PH_IDLE;
			fin = 1;
		endfunction

		function void enter_open();
			logic [15:0] o;
			if (opening != 0) begin
				o = opening & valve_bits();
				full_d |= o;
				pwm_d &= ~o;
				ramp_d &= ~o;
				period = (w_odly > OPEN_DELAY_CAP_DEF) ? 16'(OPEN_DELAY_CAP_DEF) : w_odly;
				ms_cnt = '0;
				ph = PH_OPEN;
			end else begin
				finish();
			end
		endfunction

		function void launch(logic [15:0] req);
			int t;
			t = (w_cdly > CLOSE_DELAY_CAP_DEF) ? CLOSE_DELAY_CAP_DEF : int'(w_cdly);
			target = (req & IO_BITS) | (r_ext & EX_BITS);
			closing = status & ~target;
			opening = target & ~status;
			ramp_val = hold_value();
			if (closing != 0) begin
				if (steps_left == 0) steps_left = 8'd1;
				ramp_dec = ramp_val / steps_left;
				period = 16'(t / int'(steps_left));
				ms_cnt = '0;
				ph = PH_CLOSE;
			end else begin
				enter_open();
			end
		endfunction

		function bit elapsed();
			logic [15:0] p;
			p = (period == 0) ? 16'd1 : period;
			ms_cnt = ms_cnt + 16'd1;
			if (ms_cnt >= p) begin
				ms_cnt = '0;
				return 1;
			end
			return 0;
		endfunction

		function void tick();
			logic [15:0] c, o;
			c = closing & valve_bits();
			o = opening & valve_bits();
			if (ph == PH_CLOSE) begin
				if (!elapsed()) return;
				steps_left = steps_left - 8'd1;
				if (steps_left != 0) begin
					ramp_val = (ramp_val > ramp_dec) ? ramp_val - ramp_dec : 13'd0;
					ramp_d |= c; pwm_d &= ~c; full_d &= ~c;
				end else begin
					ramp_val = '0;
					ramp_d &= ~c; pwm_d &= ~c; full_d &= ~c;
					enter_open();
				end
			end else if (ph == PH_OPEN) begin
				if (!elapsed()) return;
				pwm_d |= o; full_d &= ~o; ramp_d &= ~o;
				finish();
			end
		endfunction

		function void note_input(in_word_t w);
			out_word_t e;
			fin = 0;
			case (w.action)
				ACT_TICK: tick();
				ACT_REQ: begin
					w_duty = r_duty; w_cdly = r_cdly; w_odly = r_odly;
					steps_left = r_steps;
					launch(w.request_mask);
				end
				ACT_BREAK: launch(16'h0000);
				default: ;
			endcase
			e.full_on_mask  = full_d;
			e.hold_pwm_mask = pwm_d;
			e.ramp_pwm_mask = ramp_d;
			e.hold_compare  = hold_value();
			e.ramp_compare  = (ph == PH_CLOSE) ? ramp_val : 13'd0;
			e.valve_status  = status;
			e.seq_phase     = fin ? PH_DONE : ph;
			e.done_res      = fin;
			pending.push_back(e);
		endfunction

		function void check_result(out_word_t got);
			out_word_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word %h", got);
				return;
			end
			e = pending.pop_front();
			if (got.done_res) done_seen++;
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch #%0d: exp %h got %h", checked, e, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	vss_stream_if #(.T(in_word_t))  in_ch ();
	vss_stream_if #(.T(out_word_t)) out_ch ();

	valve_switch_sequencer u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	valve_scoreboard sb;
	bit hold_off;
	int items_sent;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: stall pattern plus a long forced hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
			if (hold_off) out_ch.ready <= 1'b0;
			else if (items_sent[8]) out_ch.ready <= 1'b1;
			else out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_word(logic [1:0] act, logic [15:0] req);
		in_word_t w;
		w.action = act;
		w.request_mask = req;
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(w);
		items_sent++;
		if ($urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// cfg_we stays high across a series; the caller drops it afterwards
	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic ticks(int n);
		repeat (n) send_word(ACT_TICK, 16'($urandom));
	endtask

	task automatic rand_phase(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 8) send_word(ACT_REQ, 16'($urandom));
			else if (k < 10) send_word(ACT_BREAK, 16'($urandom));
			else if (k < 11) send_word(2'd3, 16'($urandom));
			else send_word(ACT_TICK, 16'($urandom));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_EXT;
		cfg_data = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		hold_off = 0;
		items_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, open/close/break/ignored action
		send_word(ACT_TICK, 16'h0000);
		send_word(ACT_REQ, 16'hFFFF);
		ticks(2);
		send_word(ACT_REQ, 16'h0000);
		ticks(2);
		send_word(ACT_REQ, 16'h0000);
		send_word(2'd3, 16'hFFFF);
		drain();
		write_reg(REG_EXT, 16'hFFFF);
		write_reg(REG_DUTY, 16'd127);
		write_reg(REG_CDLY, 16'hFFFF);
		write_reg(REG_STEPS, 16'd255);
		write_reg(REG_ODLY, 16'hFFFF);
		cfg_we <= 1'b0;
		send_word(ACT_REQ, 16'hA5A0);
		ticks(3);
		send_word(ACT_REQ, 16'h5A50);
		ticks(6);
		send_word(ACT_BREAK, 16'hFFFF);
		ticks(5);
		drain();

		// long receiver stall while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			rand_phase(20);
		join
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_EXT, 16'($urandom));
			write_reg(REG_DUTY, (ph == 0) ? 16'd0 : 16'($urandom_range(0, 127)));
			write_reg(REG_CDLY, (ph == 1) ? 16'hFFFF : 16'($urandom_range(0, 40)));
			write_reg(REG_STEPS, (ph == 2) ? 16'd0 : 16'($urandom_range(0, 12)));
			write_reg(REG_ODLY, (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 20)));
			cfg_we <= 1'b0;
			rand_phase(115);
			drain();
		end

		$display("covered %0d words, %0d results, %0d finished sequences",
			items_sent, sb.checked, sb.done_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+sv
sv/vss_pkg.sv
sv/vss_stream_if.sv
sv/vss_datapath.sv
sv/vss_ctrl.sv
sv/valve_switch_sequencer.sv
sim/valve_switch_sequencer_tb.sv
